FILE: hdl/led_matrix_frame_buffer_defines.svh
// Assertion macros shared by the checker of the LED matrix frame buffer.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef LED_MATRIX_FRAME_BUFFER_DEFINES_SVH
`define LED_MATRIX_FRAME_BUFFER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LMFB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LMFB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/lmfb_pkg.sv
// Package of the LED matrix frame buffer: geometry, opcodes, colors and
// configuration register indexes. No dependencies.
package lmfb_pkg;

  localparam int MATRIX_ROWS  = 16;
  localparam int MODULE_WIDTH = 16;
  localparam int MAX_MODULES  = 4;
  localparam int ROW_WORD     = 64;
  localparam int ROW_BITS     = 4;
  localparam int DOT_BITS     = 6;
  localparam int WIDTH_BITS   = DOT_BITS + 1;
  localparam int MOD_STEPS    = (ROW_WORD + MODULE_WIDTH - 1) / MODULE_WIDTH;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_DRAW   = 2'd1;
  localparam logic [1:0] OP_ROTATE = 2'd2;
  localparam logic [1:0] OP_SEND   = 2'd3;

  localparam logic [1:0] COLOR_RED    = 2'd0;
  localparam logic [1:0] COLOR_GREEN  = 2'd1;
  localparam logic [1:0] COLOR_ORANGE = 2'd2;
  localparam logic [1:0] COLOR_NONE   = 2'd3;

  localparam logic [1:0] CFG_MODULE_COUNT = 2'd0;
  localparam logic [1:0] CFG_GLYPH_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_GLYPH_HEIGHT = 2'd2;

  typedef logic [ROW_WORD-1:0] row_t;

endpackage

FILE: hdl/lmfb_if.sv
// Handshake channels of the LED matrix frame buffer: commands in, dots out.
// Depends on lmfb_pkg.
interface lmfb_in_if;
  import lmfb_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          opcode;
  logic [ROW_WORD-1:0] glyph_columns;
  logic [1:0]          color;
  logic [7:0]          char_col;
  logic [7:0]          char_row;
  logic [5:0]          shift_count;
  logic [3:0]          row_index;

  modport source (output valid, opcode, glyph_columns, color, char_col, char_row,
                  shift_count, row_index, input ready);
  modport sink (input valid, opcode, glyph_columns, color, char_col, char_row,
                shift_count, row_index, output ready);
endinterface

interface lmfb_out_if;
  logic       valid;
  logic       ready;
  logic       dot_red;
  logic       dot_green;
  logic [3:0] row_address;
  logic       row_latch;

  modport source (output valid, dot_red, dot_green, row_address, row_latch,
                  input ready);
  modport sink (input valid, dot_red, dot_green, row_address, row_latch,
                output ready);
endinterface

FILE: hdl/led_matrix_frame_buffer.sv
// Top level of the two-color LED matrix frame buffer.
// Depends on lmfb_pkg, lmfb_in_if, lmfb_out_if and lmfb_ram.
//
// Commands arrive on cmd and dots leave on dots; each moves by a valid/ready
// transfer. Registers module_count, glyph_width and glyph_height are written
// through cfg_we, cfg_index and cfg_data, by the user only while the block
// is idle; the block itself does not enforce this. Both color planes live in
// one 16-row RAM, red in the low half of a word and green in the high half,
// with a valid bit per row so that unwritten rows read as dark.
// Clear takes the transfer cycle only; it drops every valid bit.
// Draw touches glyph_height rows (1 to 8) and rotate touches all 16 rows,
// each row in a RAM read state, then a modify and write-back state.
// Send row reads its row in the RAM read state and then presents one dot
// per cycle while the receiver is ready, for display width dots (16 to 64);
// the last dot carries the latch and row address. cmd.ready is high only
// while no command is in progress. When the receiver stalls, the current dot
// is held in the output register and the dot sequence waits. Reset empties
// the buffer and restores module_count 1, glyph_width 5 and glyph_height 7.
module led_matrix_frame_buffer (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [3:0]        cfg_data,
  lmfb_in_if.sink           cmd,
  lmfb_out_if.source        dots
);
  import lmfb_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_MOD  = 2'd2;
  localparam logic [1:0] S_SEND = 2'd3;

  logic [1:0]            state;
  logic [2:0]            module_count;
  logic [3:0]            glyph_width;
  logic [3:0]            glyph_height;

  logic [1:0]            op;
  row_t                  cols;
  logic [1:0]            color;
  logic [DOT_BITS-1:0]   rot_k;
  logic [DOT_BITS-1:0]   x0;
  logic [ROW_BITS-1:0]   row;
  logic [2:0]            step;
  logic                  dark;
  logic [MATRIX_ROWS-1:0] row_valid;
  logic                  rd_ok;
  row_t                  sh_red;
  row_t                  sh_green;
  logic [DOT_BITS-1:0]   dot_cnt;

  logic                  out_valid;
  logic                  out_red;
  logic                  out_green;
  logic [3:0]            out_addr;
  logic                  out_latch;

  logic [2:0]            eff_mods;
  logic [3:0]            eff_gw;
  logic [3:0]            eff_gh;
  logic [12:0]           width_prod;
  logic [WIDTH_BITS-1:0] width;
  row_t                  wmask;
  logic [11:0]           span_c;
  logic [11:0]           span_r;
  logic                  draw_hit;
  logic [WIDTH_BITS-1:0] k_calc;
  logic                  accept;
  logic                  out_free;
  logic                  send_last;

  logic [2*ROW_WORD-1:0] ram_rdata;
  logic [2*ROW_WORD-1:0] ram_wdata;
  logic                  ram_we;
  row_t                  rd_red;
  row_t                  rd_green;
  logic [7:0]            pat;
  row_t                  pat_row;
  row_t                  new_red;
  row_t                  new_green;
  row_t                  rot_red;
  row_t                  rot_green;

  // Effective geometry from the configuration registers.
  always_comb begin
    eff_mods = module_count;
    if (module_count == 3'd0) begin
      eff_mods = 3'd1;
    end else if ({1'b0, module_count} > 4'(MAX_MODULES)) begin
      eff_mods = 3'(MAX_MODULES);
    end
    width_prod = 13'(eff_mods) * 13'(MODULE_WIDTH);
    width = (width_prod > 13'(ROW_WORD)) ? WIDTH_BITS'(ROW_WORD)
                                         : width_prod[WIDTH_BITS-1:0];
    wmask = (width == WIDTH_BITS'(ROW_WORD)) ? '1 : ((row_t'(1) << width) - row_t'(1));
    eff_gw = (glyph_width == 4'd0) ? 4'd1 : (glyph_width > 4'd8) ? 4'd8 : glyph_width;
    eff_gh = (glyph_height == 4'd0) ? 4'd1 : (glyph_height > 4'd8) ? 4'd8 : glyph_height;
  end

  // Cell bounds: col < W / gw holds exactly when (col + 1) * gw <= W.
  always_comb begin
    span_c = (12'(cmd.char_col) + 12'd1) * 12'(eff_gw);
    span_r = (12'(cmd.char_row) + 12'd1) * 12'(eff_gh);
    draw_hit = (span_c <= 12'(width)) && (span_r <= 12'(MATRIX_ROWS))
               && (cmd.color != COLOR_NONE);
    k_calc = WIDTH_BITS'(cmd.shift_count);
    for (int s = 0; s < MOD_STEPS; s++) begin
      if (k_calc >= width) begin
        k_calc = k_calc - width;
      end
    end
  end

  assign accept   = cmd.valid && cmd.ready;
  assign cmd.ready = (state == S_IDLE);
  assign out_free = !out_valid || dots.ready;
  assign send_last = (WIDTH_BITS'(dot_cnt) + WIDTH_BITS'(1)) == width;

  // Read-modify-write of one row.
  always_comb begin
    rd_red   = rd_ok ? ram_rdata[ROW_WORD-1:0] : '0;
    rd_green = rd_ok ? ram_rdata[2*ROW_WORD-1:ROW_WORD] : '0;
    for (int i = 0; i < 8; i++) begin
      pat[i] = (4'(i) < eff_gw) ? cols[{3'(i), step}] : 1'b0;
    end
    pat_row = row_t'(pat) << x0;
    rot_red = (((rd_red & wmask) >> rot_k) | ((rd_red & wmask) << (width - WIDTH_BITS'(rot_k))))
              & wmask;
    rot_green = (((rd_green & wmask) >> rot_k)
                 | ((rd_green & wmask) << (width - WIDTH_BITS'(rot_k)))) & wmask;
    if (op == OP_DRAW) begin
      new_red   = (color == COLOR_RED || color == COLOR_ORANGE) ? (rd_red | pat_row) : rd_red;
      new_green = (color == COLOR_GREEN || color == COLOR_ORANGE) ? (rd_green | pat_row)
                                                                  : rd_green;
    end else if (rot_k == '0) begin
      new_red   = rd_red;
      new_green = rd_green;
    end else begin
      new_red   = (rd_red & ~wmask) | rot_red;
      new_green = (rd_green & ~wmask) | rot_green;
    end
    ram_wdata = {new_green, new_red};
    ram_we    = (state == S_MOD) && (op != OP_SEND);
  end

  lmfb_ram #(
    .WIDTH(2 * ROW_WORD),
    .DEPTH(MATRIX_ROWS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(row),
    .wdata(ram_wdata),
    .raddr(row),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      module_count <= 3'd1;
      glyph_width  <= 4'd5;
      glyph_height <= 4'd7;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODULE_COUNT: module_count <= cfg_data[2:0];
        CFG_GLYPH_WIDTH:  glyph_width  <= cfg_data;
        CFG_GLYPH_HEIGHT: glyph_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_ok <= row_valid[row];
    if (accept) begin
      op    <= cmd.opcode;
      cols  <= cmd.glyph_columns;
      color <= cmd.color;
      rot_k <= k_calc[DOT_BITS-1:0];
      x0    <= DOT_BITS'(span_c - 12'(eff_gw));
      step  <= 3'd0;
      dark  <= ({1'b0, cmd.row_index} >= 5'(MATRIX_ROWS));
      row   <= (cmd.opcode == OP_DRAW) ? ROW_BITS'(span_r - 12'(eff_gh))
             : (cmd.opcode == OP_SEND) ? cmd.row_index : '0;
    end else if (state == S_MOD && op != OP_SEND) begin
      row  <= row + ROW_BITS'(1);
      step <= step + 3'd1;
    end
    if (state == S_MOD && op == OP_SEND) begin
      sh_red   <= dark ? '0 : rd_red;
      sh_green <= dark ? '0 : rd_green;
      dot_cnt  <= '0;
    end else if (state == S_SEND && out_free) begin
      sh_red   <= sh_red >> 1;
      sh_green <= sh_green >> 1;
      dot_cnt  <= dot_cnt + DOT_BITS'(1);
    end
    if (state == S_SEND && out_free) begin
      out_red   <= sh_red[0];
      out_green <= sh_green[0];
      out_addr  <= send_last ? row : '0;
      out_latch <= send_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      row_valid <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_SEND && out_free) begin
        out_valid <= 1'b1;
      end else if (dots.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (cmd.opcode)
              OP_CLEAR: row_valid <= '0;
              OP_DRAW:  state <= draw_hit ? S_READ : S_IDLE;
              default:  state <= S_READ;
            endcase
          end
        end
        S_READ: state <= S_MOD;
        S_MOD: begin
          if (op == OP_SEND) begin
            state <= S_SEND;
          end else begin
            row_valid[row] <= 1'b1;
            if ((op == OP_DRAW && step == 3'(eff_gh - 4'd1))
                || (op == OP_ROTATE && row == ROW_BITS'(MATRIX_ROWS - 1))) begin
              state <= S_IDLE;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_SEND: begin
          if (out_free && send_last) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign dots.valid       = out_valid;
  assign dots.dot_red     = out_red;
  assign dots.dot_green   = out_green;
  assign dots.row_address = out_addr;
  assign dots.row_latch   = out_latch;

endmodule

FILE: hdl/lmfb_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module lmfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/lmfb_checker.sv
// Port-level checker for the LED matrix frame buffer and its bind statement.
// Depends on led_matrix_frame_buffer_defines.svh, lmfb_pkg and the top level.
`include "led_matrix_frame_buffer_defines.svh"

module lmfb_checker (
  input logic       clk,
  input logic       rst,
  input logic       cmd_valid,
  input logic       cmd_ready,
  input logic [1:0] cmd_opcode,
  input logic       dot_valid,
  input logic       dot_ready,
  input logic       dot_red,
  input logic       dot_green,
  input logic [3:0] row_address,
  input logic       row_latch
);
  import lmfb_pkg::*;

  // A stalled dot must stay on the port unchanged.
  `LMFB_ASSERT_NEXT(a_stall_hold, dot_valid && !dot_ready,
    dot_valid && $stable(dot_red) && $stable(dot_green) && $stable(row_address)
    && $stable(row_latch), "stalled dot changed")

  // Only the latched last dot of a row carries a row address.
  `LMFB_ASSERT_NOW(a_addr_zero, dot_valid && !row_latch, row_address == 4'd0,
    "row address on a dot without latch")

  // A clear finishes in its own transfer cycle.
  `LMFB_ASSERT_NEXT(a_clear_quick, cmd_valid && cmd_ready && cmd_opcode == OP_CLEAR,
    cmd_ready, "busy after clear")

  // A send keeps the command channel closed while its row is read.
  `LMFB_ASSERT_NEXT(a_send_busy, cmd_valid && cmd_ready && cmd_opcode == OP_SEND,
    !cmd_ready, "command taken during send")

endmodule

bind led_matrix_frame_buffer lmfb_checker u_lmfb_checker (
  .clk        (clk),
  .rst        (rst),
  .cmd_valid  (cmd.valid),
  .cmd_ready  (cmd.ready),
  .cmd_opcode (cmd.opcode),
  .dot_valid  (dots.valid),
  .dot_ready  (dots.ready),
  .dot_red    (dots.dot_red),
  .dot_green  (dots.dot_green),
  .row_address(dots.row_address),
  .row_latch  (dots.row_latch)
);

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench of the LED matrix frame buffer: a queue-fed command
// driver, a dot monitor and a built-in model of both color planes.
// Depends on lmfb_pkg, lmfb_in_if, lmfb_out_if and led_matrix_frame_buffer.
module tb_top;
  import lmfb_pkg::*;

  localparam int CLK_HALF = 2;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES = 500;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [1:0]  opcode;
    logic [63:0] glyph_columns;
    logic [1:0]  color;
    logic [7:0]  char_col;
    logic [7:0]  char_row;
    logic [5:0]  shift_count;
    logic [3:0]  row_index;
    bit          drain_first;
  } command_t;

  typedef struct packed {
    logic       dot_red;
    logic       dot_green;
    logic [3:0] row_address;
    logic       row_latch;
  } dot_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_MODULE_COUNT;
  logic [3:0] cfg_data = '0;

  lmfb_in_if cmd ();
  lmfb_out_if dots ();

  led_matrix_frame_buffer u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .dots      (dots)
  );

  row_t red_rows [MATRIX_ROWS];
  row_t green_rows [MATRIX_ROWS];
  logic [2:0] module_count;
  logic [3:0] glyph_width;
  logic [3:0] glyph_height;

  command_t pending_q [$];
  dot_t dots_due [$];
  command_t in_flight;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  bit pressure_on = 1'b0;
  bit cmd_fire = 1'b0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int mismatches = 0;
  int cycle_count = 0;

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb_top NOT OK");
    $finish;
  end

  function automatic int display_width();
    int m;
    m = int'(module_count);
    if (m < 1) m = 1;
    if (m > MAX_MODULES) m = MAX_MODULES;
    return (m * MODULE_WIDTH > ROW_WORD) ? ROW_WORD : m * MODULE_WIDTH;
  endfunction

  function automatic int clamp_glyph(logic [3:0] g);
    if (g < 1) return 1;
    if (g > 8) return 8;
    return int'(g);
  endfunction

  function automatic row_t rotate_left(row_t r, int w, int k);
    row_t m;
    row_t v;
    m = (w >= ROW_WORD) ? '1 : ((row_t'(1) << w) - row_t'(1));
    v = r & m;
    if (k == 0) return r;
    v = ((v >> k) | (v << (w - k))) & m;
    return (r & ~m) | v;
  endfunction

  function automatic void apply_command(command_t c);
    int w;
    int gw;
    int gh;
    int x;
    int y;
    int k;
    row_t bit_mask;
    logic [7:0] column;
    dot_t d;
    w = display_width();
    case (c.opcode)
      OP_CLEAR: begin
        foreach (red_rows[i]) begin
          red_rows[i] = '0;
          green_rows[i] = '0;
        end
      end
      OP_DRAW: begin
        gw = clamp_glyph(glyph_width);
        gh = clamp_glyph(glyph_height);
        if (c.char_col < w / gw && c.char_row < MATRIX_ROWS / gh && c.color != COLOR_NONE) begin
          for (int i = 0; i < gw; i++) begin
            column = c.glyph_columns[8*i +: 8];
            for (int j = 0; j < gh; j++) begin
              if (column[j]) begin
                x = gw * int'(c.char_col) + i;
                y = (gh * int'(c.char_row) + j) % MATRIX_ROWS;
                bit_mask = row_t'(1) << x;
                if (c.color == COLOR_RED || c.color == COLOR_ORANGE) red_rows[y] |= bit_mask;
                if (c.color == COLOR_GREEN || c.color == COLOR_ORANGE)
                  green_rows[y] |= bit_mask;
              end
            end
          end
        end
      end
      OP_ROTATE: begin
        k = int'(c.shift_count) % w;
        foreach (red_rows[i]) begin
          red_rows[i] = rotate_left(red_rows[i], w, k);
          green_rows[i] = rotate_left(green_rows[i], w, k);
        end
      end
      default: begin
        for (int i = 0; i < w; i++) begin
          d.dot_red = red_rows[c.row_index][i];
          d.dot_green = green_rows[c.row_index][i];
          d.row_address = (i == w - 1) ? c.row_index : 4'd0;
          d.row_latch = (i == w - 1);
          dots_due.push_back(d);
        end
      end
    endcase
  endfunction

  function automatic command_t make_command(logic [1:0] op, logic [63:0] cols,
                                            logic [1:0] color, logic [7:0] ccol,
                                            logic [7:0] crow, logic [5:0] shift,
                                            logic [3:0] row);
    command_t c;
    c.opcode = op;
    c.glyph_columns = cols;
    c.color = color;
    c.char_col = ccol;
    c.char_row = crow;
    c.shift_count = shift;
    c.row_index = row;
    c.drain_first = 1'b0;
    return c;
  endfunction

  function automatic command_t random_command();
    command_t c;
    int pick;
    int cells_x;
    int cells_y;
    pick = $urandom_range(99);
    cells_x = display_width() / clamp_glyph(glyph_width);
    cells_y = MATRIX_ROWS / clamp_glyph(glyph_height);
    c.opcode = (pick < 3) ? OP_CLEAR : (pick < 48) ? OP_DRAW : (pick < 68) ? OP_ROTATE : OP_SEND;
    c.glyph_columns = {$urandom, $urandom};
    if ($urandom_range(3) == 0) c.glyph_columns &= {$urandom, $urandom};
    c.color = ($urandom_range(9) == 0) ? COLOR_NONE : 2'($urandom_range(2));
    if ($urandom_range(9) == 0) begin
      c.char_col = 8'($urandom);
      c.char_row = 8'($urandom);
    end else begin
      c.char_col = 8'($urandom_range(cells_x));
      c.char_row = 8'($urandom_range(cells_y));
    end
    c.shift_count = 6'($urandom);
    c.row_index = 4'($urandom);
    c.drain_first = 1'b0;
    return c;
  endfunction

  always @(posedge clk) begin : accept
    cmd_fire <= !rst && cmd.valid && cmd.ready;
    if (!rst && cmd.valid && cmd.ready) apply_command(in_flight);
  end

  always @(negedge clk) begin : driver
    if (rst) begin
      cmd.valid <= 1'b0;
    end else if (!cmd.valid || cmd_fire) begin
      if (pending_q.size() != 0 && $urandom_range(99) >= src_idle_pct &&
          !(pending_q[0].drain_first && dots_due.size() != 0)) begin
        in_flight = pending_q.pop_front();
        cmd.valid <= 1'b1;
        cmd.opcode <= in_flight.opcode;
        cmd.glyph_columns <= in_flight.glyph_columns;
        cmd.color <= in_flight.color;
        cmd.char_col <= in_flight.char_col;
        cmd.char_row <= in_flight.char_row;
        cmd.shift_count <= in_flight.shift_count;
        cmd.row_index <= in_flight.row_index;
      end else begin
        cmd.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : sink
    if (rst) begin
      dots.ready <= 1'b0;
    end else if (hold_left > 0) begin
      dots.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (pressure_on && !hold_done && dots.valid) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
      dots.ready <= 1'b0;
    end else begin
      dots.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin : monitor
    dot_t seen;
    dot_t want;
    if (!rst && dots.valid && dots.ready) begin
      seen = {dots.dot_red, dots.dot_green, dots.row_address, dots.row_latch};
      if (dots_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected dot: red %0b green %0b row %0d latch %0b",
                   seen.dot_red, seen.dot_green, seen.row_address, seen.row_latch);
      end else begin
        want = dots_due.pop_front();
        if (seen !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"dot mismatch: expected red %0b green %0b row %0d latch %0b, ",
                      "got red %0b green %0b row %0d latch %0b"},
                     want.dot_red, want.dot_green, want.row_address, want.row_latch,
                     seen.dot_red, seen.dot_green, seen.row_address, seen.row_latch);
        end
      end
    end
  end

  task automatic wait_idle();
    while (pending_q.size() != 0 || cmd.valid || dots_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [3:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      CFG_MODULE_COUNT: module_count = value[2:0];
      CFG_GLYPH_WIDTH:  glyph_width = value;
      default:          glyph_height = value;
    endcase
  endtask

  task automatic run_phase(logic [3:0] mc, logic [3:0] gw, logic [3:0] gh,
                           int idle_in, int stall_out, int count, bit pressure);
    command_t c;
    wait_idle();
    write_reg(CFG_MODULE_COUNT, mc);
    write_reg(CFG_GLYPH_WIDTH, gw);
    write_reg(CFG_GLYPH_HEIGHT, gh);
    @(negedge clk) cfg_we <= 1'b0;
    @(posedge clk);
    src_idle_pct = idle_in;
    sink_stall_pct = stall_out;
    pressure_on = pressure;
    for (int n = 0; n < count; n++) begin
      c = random_command();
      c.drain_first = pressure && (n % 16 == 15);
      pending_q.push_back(c);
    end
  endtask

  initial begin : stimulus
    cmd.valid = 1'b0;
    cmd.opcode = OP_CLEAR;
    cmd.glyph_columns = '0;
    cmd.color = COLOR_RED;
    cmd.char_col = '0;
    cmd.char_row = '0;
    cmd.shift_count = '0;
    cmd.row_index = '0;
    dots.ready = 1'b0;
    foreach (red_rows[i]) begin
      red_rows[i] = '0;
      green_rows[i] = '0;
    end
    module_count = 3'd1;
    glyph_width = 4'd5;
    glyph_height = 4'd7;

    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Reset geometry: 16 dots wide, 5x7 cells, so three cells across and two down.
    pending_q.push_back(make_command(OP_SEND, '0, COLOR_RED, 0, 0, 0, 0));
    pending_q.push_back(make_command(OP_DRAW, '1, COLOR_RED, 0, 0, 0, 0));
    pending_q.push_back(make_command(OP_DRAW, 64'h00AA_55AA_55AA_55AA, COLOR_GREEN, 1, 0, 0, 0));
    pending_q.push_back(make_command(OP_DRAW, 64'h0041_2214_0814_2241, COLOR_ORANGE, 2, 1, 0, 0));
    pending_q.push_back(make_command(OP_DRAW, '1, COLOR_NONE, 0, 1, 0, 0));
    pending_q.push_back(make_command(OP_DRAW, '1, COLOR_RED, 3, 0, 0, 0));
    pending_q.push_back(make_command(OP_DRAW, '1, COLOR_GREEN, 0, 2, 0, 0));
    pending_q.push_back(make_command(OP_DRAW, '1, COLOR_ORANGE, 8'd255, 8'd255, 6'd63, 4'd15));
    pending_q.push_back(make_command(OP_SEND, '0, COLOR_RED, 0, 0, 0, 0));
    pending_q.push_back(make_command(OP_SEND, '0, COLOR_RED, 0, 0, 0, 6));
    pending_q.push_back(make_command(OP_SEND, '0, COLOR_RED, 0, 0, 0, 8));
    pending_q.push_back(make_command(OP_SEND, '0, COLOR_RED, 0, 0, 0, 13));
    pending_q.push_back(make_command(OP_ROTATE, '0, COLOR_RED, 0, 0, 0, 0));
    pending_q.push_back(make_command(OP_SEND, '0, COLOR_RED, 0, 0, 0, 1));
    pending_q.push_back(make_command(OP_ROTATE, '0, COLOR_RED, 0, 0, 6'd63, 0));
    pending_q.push_back(make_command(OP_SEND, '0, COLOR_RED, 0, 0, 0, 0));
    pending_q.push_back(make_command(OP_ROTATE, '0, COLOR_RED, 0, 0, 6'd16, 0));
    pending_q.push_back(make_command(OP_SEND, '0, COLOR_RED, 0, 0, 0, 9));
    pending_q.push_back(make_command(OP_ROTATE, '0, COLOR_RED, 0, 0, 6'd5, 0));
    pending_q.push_back(make_command(OP_SEND, '0, COLOR_RED, 0, 0, 0, 7));
    pending_q.push_back(make_command(OP_SEND, '0, COLOR_RED, 0, 0, 0, 15));
    pending_q.push_back(make_command(OP_CLEAR, '0, COLOR_RED, 0, 0, 0, 0));
    pending_q.push_back(make_command(OP_SEND, '0, COLOR_RED, 0, 0, 0, 8));

    run_phase(4'd0, 4'd0, 4'd0, 48, 0, 80, 1'b0);
    run_phase(4'd4, 4'd8, 4'd8, 0, 48, 80, 1'b0);
    run_phase(4'd7, 4'd15, 4'd15, 36, 36, 80, 1'b0);
    run_phase(4'd2, 4'd3, 4'd4, 0, 0, 80, 1'b1);
    run_phase(4'd3, 4'd6, 4'd5, 0, 0, 80, 1'b0);
    run_phase(4'd13, 4'd9, 4'd2, 36, 36, 80, 1'b0);

    wait_idle();
    if (mismatches == 0 && dots_due.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
